// File: src/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned UNITS  = 4096;
  localparam int unsigned IDX_W  = $clog2(UNITS);
  localparam int unsigned ADDR_W = 13;

  typedef enum logic [1:0] {
    CMD_NEW   = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_GET   = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef struct packed {
    logic mark;
    logic occ;
  } flag_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] end_address;
  } res_t;

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_NEW_EV    = 9'b000000100,
    S_FILL      = 9'b000001000,
    S_FREE_CHK  = 9'b000010000,
    S_FREE_WALK = 9'b000100000,
    S_END_EV    = 9'b001000000,
    S_RELEASE   = 9'b010000000,
    S_GET_EV    = 9'b100000000
  } state_e;

endpackage

// File: src/first_fit_block_allocator_unit.sv
// First-fit contiguous allocator over a pool of up to 4096 units.
// Commands arrive on the s_axis channel: tuser carries the command (new, free,
// get, reset pool), tdata the 13-bit operand. Each command gives exactly one
// result transfer on m_axis: tuser is the status (1 rejected), tdata carries
// the start and end units. The pool size is written on the cfg channel and is
// taken up by the next reset-pool command.
// One command is worked on at a time; the state sits in a 4096-entry flag
// ram (occupied, block start) and a 4096-entry block end ram, one unit
// visited per cycle:
//   new:   scan up to the first-fit end unit, then fill the block's units
//   free:  walk back to the block start, read its end, then release the block's units
//   get:   scan up to the unit of the found block (or the pool size)
//   reset: clearing pass over the whole flag ram
// Bad operands are rejected. After rst_ni the block runs the
// same clearing pass and accepts no command meanwhile; cfg writes
// are taken at any time. A stalled receiver holds the result in the output
// register; a second finished result waits inside and blocks new commands.
module first_fit_block_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [12:0] operand, zero filled above
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [12:0] start_address, [25:13] end_address
  output logic        m_axis_tuser_o,   // [0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i        // unit_count
);
  import ffba_pkg::*;

  logic [ADDR_W-1:0] unit_count_q;
  logic [IDX_W-1:0]  rd_idx, wr_idx;
  logic              flag_we, end_we;
  flag_t             flag_wdata, flag_rdata;
  logic [ADDR_W-1:0] end_wdata, end_rdata;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_count_q <= ADDR_W'(UNITS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unit_count_q <= cfg_data_i;
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_op_i      (s_axis_tdata_i[ADDR_W-1:0]),
    .unit_count_i (unit_count_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res),
    .rd_idx_o     (rd_idx),
    .wr_idx_o     (wr_idx),
    .flag_we_o    (flag_we),
    .flag_wdata_o (flag_wdata),
    .end_we_o     (end_we),
    .end_wdata_o  (end_wdata),
    .flag_rdata_i (flag_rdata),
    .end_rdata_i  (end_rdata)
  );

  ffba_ram #(.Width(2), .Depth(UNITS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (wr_idx),
    .wdata_i (flag_wdata),
    .raddr_i (rd_idx),
    .rdata_o (flag_rdata)
  );

  ffba_ram #(.Width(ADDR_W), .Depth(UNITS)) u_end_ram (
    .clk_i   (clk_i),
    .we_i    (end_we),
    .waddr_i (wr_idx),
    .wdata_i (end_wdata),
    .raddr_i (rd_idx),
    .rdata_o (end_rdata)
  );

  assign m_axis_tuser_o = res.status;
  assign m_axis_tdata_o = {6'd0, res.end_address, res.start_address};

  // rejected results carry no addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("rejected result with nonzero address");

  // a block never ends before it starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o && res.end_address != '0
      |-> res.start_address <= res.end_address)
    else $error("block end below block start");

  // a command transfer is never followed by another in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken while previous one in flight");

  // the rams are never written while a command can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !flag_we && !end_we)
    else $error("ram write while idle");

endmodule

// File: src/ffba_ram.sv
// single-port-write, single-port-read synchronous ram with registered read
module ffba_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/ffba_ctrl.sv
// command sequencer: walks the unit flags and block ends one unit per step
module ffba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   in_op_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   unit_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffba_pkg::res_t                out_o,
  output logic [ffba_pkg::IDX_W-1:0]    rd_idx_o,
  output logic [ffba_pkg::IDX_W-1:0]    wr_idx_o,
  output logic                          flag_we_o,
  output ffba_pkg::flag_t               flag_wdata_o,
  output logic                          end_we_o,
  output logic [ffba_pkg::ADDR_W-1:0]   end_wdata_o,
  input  ffba_pkg::flag_t               flag_rdata_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   end_rdata_i
);
  import ffba_pkg::*;

  localparam logic [ADDR_W-1:0] UnitsA = ADDR_W'(UNITS);
  localparam logic [ADDR_W-1:0] One    = ADDR_W'(1);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] u_q, u_d, run_q, run_d, op_q, op_d;
  logic [ADDR_W-1:0] s_q, s_d, e_q, e_d, i_q, i_d, active_q, active_d;
  logic              pend_q, pend_d, done_q, done_d;
  res_t              res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] rd_tmp, wr_tmp, run_inc;
  logic              finish;
  res_t              fin_res;

  assign in_ready_o  = (state_q == S_IDLE) && !done_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign run_inc     = run_q + One;
  assign rd_tmp      = u_d - One;
  assign rd_idx_o    = rd_tmp[IDX_W-1:0];
  assign wr_tmp      = i_q - One;
  assign wr_idx_o    = wr_tmp[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    u_d         = u_q;
    run_d       = run_q;
    op_d        = op_q;
    s_d         = s_q;
    e_d         = e_q;
    i_d         = i_q;
    active_d    = active_q;
    pend_d      = pend_q;
    done_d      = done_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    finish      = 1'b0;
    fin_res     = '{status: 1'b1, start_address: '0, end_address: '0};
    flag_we_o    = 1'b0;
    flag_wdata_o = '{mark: 1'b0, occ: 1'b0};
    end_we_o     = 1'b0;
    end_wdata_o  = e_q;

    unique case (state_q)
      S_CLEAR: begin
        flag_we_o = 1'b1;
        if (i_q == UnitsA) begin
          if (pend_q) begin
            finish  = 1'b1;
            fin_res = '{status: 1'b0, start_address: '0, end_address: '0};
          end else begin
            state_d = S_IDLE;
          end
          pend_d = 1'b0;
        end else begin
          i_d = i_q + One;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d  = in_op_i;
          run_d = '0;
          unique case (cmd_e'(in_cmd_i))
            CMD_NEW: begin
              u_d = One;
              if (in_op_i == '0 || in_op_i > active_q) finish = 1'b1;
              else state_d = S_NEW_EV;
            end
            CMD_FREE: begin
              u_d = in_op_i;
              if (in_op_i == '0 || in_op_i > active_q) finish = 1'b1;
              else state_d = S_FREE_CHK;
            end
            CMD_GET: begin
              u_d = One;
              if (in_op_i == '0 || active_q == '0) finish = 1'b1;
              else state_d = S_GET_EV;
            end
            CMD_RESET: begin
              active_d = (unit_count_i > UnitsA) ? UnitsA : unit_count_i;
              i_d      = One;
              pend_d   = 1'b1;
              state_d  = S_CLEAR;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_NEW_EV: begin
        if (flag_rdata_i.occ) begin
          run_d = '0;
          if (u_q == active_q) finish = 1'b1;
          else u_d = u_q + One;
        end else if (run_inc == op_q) begin
          s_d     = u_q - op_q + One;
          e_d     = u_q;
          i_d     = u_q - op_q + One;
          state_d = S_FILL;
        end else begin
          run_d = run_inc;
          if (u_q == active_q) finish = 1'b1;
          else u_d = u_q + One;
        end
      end
      S_FILL: begin
        flag_we_o    = 1'b1;
        flag_wdata_o = '{mark: (i_q == s_q), occ: 1'b1};
        end_we_o     = (i_q == s_q);
        if (i_q == e_q) begin
          finish  = 1'b1;
          fin_res = '{status: 1'b0, start_address: s_q, end_address: e_q};
        end else begin
          i_d = i_q + One;
        end
      end
      S_FREE_CHK, S_FREE_WALK: begin
        if (state_q == S_FREE_CHK && !flag_rdata_i.occ) begin
          finish = 1'b1;
        end else if (flag_rdata_i.mark) begin
          state_d = S_END_EV;
        end else if (u_q == One) begin
          finish = 1'b1;
        end else begin
          u_d     = u_q - One;
          state_d = S_FREE_WALK;
        end
      end
      S_END_EV: begin
        if (end_rdata_i < op_q || end_rdata_i > active_q) begin
          finish = 1'b1;
        end else begin
          s_d     = u_q;
          i_d     = u_q;
          e_d     = end_rdata_i;
          state_d = S_RELEASE;
        end
      end
      S_RELEASE: begin
        flag_we_o = 1'b1;
        if (i_q == e_q) begin
          finish  = 1'b1;
          fin_res = '{status: 1'b0, start_address: s_q, end_address: e_q};
        end else begin
          i_d = i_q + One;
        end
      end
      S_GET_EV: begin
        if (flag_rdata_i.mark && run_inc == op_q) begin
          finish  = 1'b1;
          fin_res = '{status: 1'b0, start_address: u_q, end_address: '0};
        end else begin
          if (flag_rdata_i.mark) run_d = run_inc;
          if (u_q == active_q) finish = 1'b1;
          else u_d = u_q + One;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      res_d   = fin_res;
      done_d  = 1'b1;
      state_d = S_IDLE;
    end

    // hand the held result to the output register once it is free
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (done_q && (!out_valid_q || out_ready_i)) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      done_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      i_q         <= One;
      active_q    <= UnitsA;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      active_q    <= active_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    run_q <= run_d;
    op_q  <= op_d;
    s_q   <= s_d;
    e_q   <= e_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

// File: bench/first_fit_block_allocator_unit_tb.sv
// self-checking testbench for the first-fit block allocator: directed rows, then random phases
module first_fit_block_allocator_unit_tb;
  import ffba_pkg::*;

  localparam int unsigned MAX_CYCLES = 4_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [12:0] operand, zero filled above
  logic [1:0]  s_axis_tuser_i;   // [1:0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [12:0] start_address, [25:13] end_address
  logic        m_axis_tuser_o;   // [0] status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i;       // unit_count

  first_fit_block_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the pool
  bit               occ_map   [UNITS];
  bit               start_map [UNITS];
  logic [12:0]      end_map   [UNITS];
  int unsigned      pool_units = UNITS;
  int unsigned      pool_cfg   = UNITS;
  int unsigned      live_blocks = 0;

  res_t result_q[$];
  int   errors = 0;
  bit   calm = 1'b0;
  bit   want_hold = 1'b0;

  typedef struct {
    cmd_e        cmd;
    logic [12:0] opnd;
    bit          typed;
    res_t        want;
  } dir_row_t;

  function automatic res_t reject_res();
    res_t r;
    r.status = 1'b1;
    r.start_address = '0;
    r.end_address = '0;
    return r;
  endfunction

  function automatic res_t done_res(int unsigned s, int unsigned e);
    res_t r;
    r.status = 1'b0;
    r.start_address = s[12:0];
    r.end_address = e[12:0];
    return r;
  endfunction

  // applies one command to the shadow pool and returns its result
  function automatic res_t alloc_predict(cmd_e c, logic [12:0] op);
    int unsigned run;
    int unsigned s;
    int unsigned e;
    int unsigned seen;
    run = 0;
    seen = 0;
    case (c)
      CMD_NEW: begin
        if (op == 0 || op > pool_units) return reject_res();
        for (int unsigned u = 1; u <= pool_units; u++) begin
          if (occ_map[u-1]) begin
            run = 0;
          end else begin
            run++;
            if (run == op) begin
              s = u - op + 1;
              for (int unsigned i = s; i <= u; i++) occ_map[i-1] = 1'b1;
              start_map[s-1] = 1'b1;
              end_map[s-1] = u[12:0];
              live_blocks++;
              return done_res(s, u);
            end
          end
        end
        return reject_res();
      end
      CMD_FREE: begin
        if (op == 0 || op > pool_units || !occ_map[op-1]) return reject_res();
        s = op;
        while (s > 1 && !start_map[s-1]) s--;
        if (!start_map[s-1]) return reject_res();
        e = end_map[s-1];
        if (e < op || e > pool_units) return reject_res();
        for (int unsigned i = s; i <= e; i++) occ_map[i-1] = 1'b0;
        start_map[s-1] = 1'b0;
        live_blocks--;
        return done_res(s, e);
      end
      CMD_GET: begin
        if (op == 0) return reject_res();
        for (int unsigned u = 1; u <= pool_units; u++) begin
          if (start_map[u-1]) begin
            seen++;
            if (seen == op) return done_res(u, 0);
          end
        end
        return reject_res();
      end
      default: begin
        for (int i = 0; i < UNITS; i++) begin
          occ_map[i] = 1'b0;
          start_map[i] = 1'b0;
          end_map[i] = '0;
        end
        live_blocks = 0;
        pool_units = (pool_cfg > UNITS) ? UNITS : pool_cfg;
        return done_res(0, 0);
      end
    endcase
  endfunction

  task automatic send_cmd(cmd_e c, logic [12:0] op, bit typed, res_t want);
    int   gap;
    res_t got;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, op};
    s_axis_tuser_i  <= c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    got = alloc_predict(c, op);
    result_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [12:0] units);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= units;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pool_cfg = units;
  endtask

  // mostly well-formed traffic sized to the current pool, some noise
  task automatic random_traffic(int n);
    int unsigned pick;
    int unsigned top;
    logic [12:0] op;
    cmd_e        c;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      top = (pool_units / 4 > 1) ? pool_units / 4 : 1;
      if (pick < 42) begin
        c = CMD_NEW;
        op = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, pool_units + 2))
                                         : 13'($urandom_range(1, top));
      end else if (pick < 74) begin
        c = CMD_FREE;
        op = 13'($urandom_range(1, (pool_units > 0) ? pool_units : 1));
        // prefer an occupied unit
        for (int t = 0; t < 8 && pool_units > 0 && !occ_map[op-1]; t++)
          op = 13'($urandom_range(1, pool_units));
      end else if (pick < 92) begin
        c = CMD_GET;
        op = 13'($urandom_range(0, live_blocks + 1));
      end else if (pick < 95) begin
        c = CMD_RESET;
        op = 13'($urandom_range(0, 8191));
      end else begin
        c = cmd_e'($urandom_range(0, 2));
        op = 13'($urandom_range(0, 8191));
      end
      send_cmd(c, op, 1'b0, reject_res());
    end
  endtask

  task automatic pool_phase(logic [12:0] units, int n);
    write_pool_size(units);
    send_cmd(CMD_RESET, 13'($urandom_range(0, 8191)), 1'b0, reject_res());
    random_traffic(n);
    drain();
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (want_hold) begin
        want_hold = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer tuser=%0d tdata=%h", $time,
                 m_axis_tuser_o, m_axis_tdata_o);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tuser_o);
        end
        if (m_axis_tdata_o[12:0] !== want.start_address) begin
          errors++;
          $display("%0t: start_address expected %0d actual %0d", $time,
                   want.start_address, m_axis_tdata_o[12:0]);
        end
        if (m_axis_tdata_o[25:13] !== want.end_address) begin
          errors++;
          $display("%0t: end_address expected %0d actual %0d", $time,
                   want.end_address, m_axis_tdata_o[25:13]);
        end
      end
    end
  end

  initial begin
    #(MAX_CYCLES * 8);
    $display("first_fit_block_allocator_unit regression: fail");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    res_t     rej;
    rej = reject_res();
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_NEW;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    for (int i = 0; i < UNITS; i++) end_map[i] = '0;

    // full pool after reset
    rows = '{
      '{CMD_GET,   13'd1,    1'b1, rej},
      '{CMD_NEW,   13'd0,    1'b1, rej},
      '{CMD_GET,   13'd0,    1'b1, rej},
      '{CMD_NEW,   13'd4097, 1'b1, rej},
      '{CMD_NEW,   13'd8191, 1'b1, rej},
      '{CMD_FREE,  13'd0,    1'b1, rej},
      '{CMD_FREE,  13'd5,    1'b1, rej},
      '{CMD_NEW,   13'd4096, 1'b1, done_res(1, 4096)},
      '{CMD_GET,   13'd1,    1'b1, done_res(1, 0)},
      '{CMD_GET,   13'd2,    1'b1, rej},
      '{CMD_NEW,   13'd1,    1'b1, rej},
      '{CMD_FREE,  13'd8191, 1'b1, rej},
      '{CMD_FREE,  13'd4096, 1'b1, done_res(1, 4096)},
      '{CMD_NEW,   13'd3,    1'b0, rej},
      '{CMD_NEW,   13'd5,    1'b0, rej},
      '{CMD_NEW,   13'd2,    1'b0, rej},
      '{CMD_FREE,  13'd2,    1'b0, rej},
      '{CMD_NEW,   13'd2,    1'b0, rej},
      '{CMD_GET,   13'd2,    1'b0, rej},
      '{CMD_FREE,  13'd7,    1'b0, rej},
      '{CMD_GET,   13'd3,    1'b0, rej},
      '{CMD_RESET, 13'd8191, 1'b1, done_res(0, 0)},
      '{CMD_GET,   13'd1,    1'b1, rej}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].opnd, rows[i].typed, rows[i].want);
    drain();

    pool_phase(13'd1, 25);
    pool_phase(13'd0, 15);
    pool_phase(13'd8191, 12);
    pool_phase(13'd16, 80);
    // long hold-off on a small pool so that short commands back up the block
    want_hold = 1'b1;
    random_traffic(40);
    drain();
    pool_phase(13'd64, 100);
    pool_phase(13'd200, 80);
    pool_phase(13'd5000, 10);
    pool_phase(13'd2, 30);
    calm = 1'b1;
    pool_phase(13'd40, 70);

    if (errors == 0) begin
      $display("first_fit_block_allocator_unit regression: pass");
    end else begin
      $display("first_fit_block_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
